// File: rtl/tmb_pkg.sv
`default_nettype none
package tmb_pkg;

    // action codes
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_STOP   = 3'd2;
    localparam logic [2:0] ACT_FORCE  = 3'd3;
    localparam logic [2:0] ACT_CHECK  = 3'd4;
    localparam logic [2:0] ACT_QUERY  = 3'd5;

    // limit markers
    localparam logic [15:0] MARK_STOPPED = 16'hFFF0;
    localparam logic [15:0] MARK_EXPIRED = 16'hFFF1;

    localparam logic [15:0] TPS_RESET = 16'd100;

    typedef struct packed {
        logic [15:0] limit;
        logic [15:0] stamp;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{limit: MARK_EXPIRED, stamp: 16'h0000};

    typedef struct packed {
        logic [15:0] fine;
        logic [15:0] second;
        logic [15:0] fine_next;
    } t_timebase;

endpackage
`default_nettype wire

// File: rtl/tmb_table.sv
`default_nettype none
module tmb_table
    import tmb_pkg::*;
#(
    parameter int TIMER_COUNT = 16,
    parameter int AW = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data
);

    t_entry                 r_mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] r_written;
    t_entry                 r_rd_word;
    logic                   r_rd_written;

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    // per-entry written flags: an unwritten entry reads as the reset entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_word : ENTRY_RESET;

endmodule
`default_nettype wire

// File: rtl/tmb_timebase.sv
`default_nettype none
module tmb_timebase
    import tmb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_tick,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    output t_timebase        o_tb
);

    logic [15:0] r_tps;
    logic [15:0] r_fine;
    logic [15:0] r_second;
    logic [15:0] r_prescale;
    logic [15:0] n_prescale_dec;

    assign n_prescale_dec = r_prescale - 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps      <= TPS_RESET;
            r_fine     <= 16'd0;
            r_second   <= 16'd0;
            r_prescale <= 16'd1;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_data;
            end
            if (i_tick) begin
                r_fine <= r_fine + 16'd1;
                if (n_prescale_dec == 16'd0) begin
                    r_prescale <= r_tps;
                    r_second   <= r_second + 16'd1;
                end else begin
                    r_prescale <= n_prescale_dec;
                end
            end
        end
    end

    assign o_tb.fine      = r_fine;
    assign o_tb.second    = r_second;
    assign o_tb.fine_next = i_tick ? r_fine + 16'd1 : r_fine;

endmodule
`default_nettype wire

// File: rtl/timeout_timer_bank_top.sv
// The o_valid strobe is registered from busy; entry read at accept, then execute.
// A new item is taken only while busy is low; busy is high for the execute cycle, when
// the entry memory's registered read data is modified and written back.
// Every item gives exactly one result, held for one cycle; the receiver cannot stall.
// Reset (i_rst_n low, synchronous): all timers expired, fine and seconds bases 0,
// prescaler 1, ticks_per_second 100; no clearing pass, per-entry flags serve instead.
`default_nettype none
module timeout_timer_bank_top
    import tmb_pkg::*;
#(
    parameter int TIMER_COUNT = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [3:0]  i_timer_index,
    input  wire logic        i_seconds_base,
    input  wire logic [15:0] i_wait_time,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_valid,
    output logic             o_expired,
    output logic [15:0]      o_remaining,
    output logic [15:0]      o_fine_now
);

    localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    // item accepted this cycle
    logic accept;
    assign accept = start && !busy;

    // item held for its execute cycle
    logic          r_busy;
    logic [2:0]    r_act;
    logic          r_idx_ok;
    logic          r_secs;
    logic [15:0]   r_wait;
    logic [AW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
        if (accept) begin
            r_act    <= i_action;
            r_idx_ok <= (32'(i_timer_index) < TIMER_COUNT);
            r_secs   <= i_seconds_base;
            r_wait   <= i_wait_time;
            r_addr   <= AW'(i_timer_index);
        end
    end

    assign busy = r_busy;

    // timer entries: read at accept, written back in the execute cycle
    t_entry rd_entry;
    t_entry n_wr_entry;
    logic   n_wr_en;

    tmb_table #(
        .TIMER_COUNT(TIMER_COUNT),
        .AW         (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_addr(AW'(i_timer_index)),
        .o_rd_data(rd_entry),
        .i_wr_en  (n_wr_en),
        .i_wr_addr(r_addr),
        .i_wr_data(n_wr_entry)
    );

    // time bases advance only on a tick in the execute cycle
    t_timebase tb;
    logic      tick;
    assign tick = r_busy && (r_act == ACT_TICK);

    tmb_timebase u_timebase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_tb      (tb)
    );

    // execute: two subtracts and compares on the fetched entry
    logic [15:0] now;
    logic [15:0] elapsed;
    logic [15:0] left;
    logic        is_marker;
    logic        n_expired;
    logic [15:0] n_remaining;

    assign now       = r_secs ? tb.second : tb.fine;
    assign elapsed   = now - rd_entry.stamp;
    assign left      = rd_entry.limit - elapsed;
    assign is_marker = (rd_entry.limit == MARK_STOPPED) || (rd_entry.limit == MARK_EXPIRED);

    always_comb begin
        n_wr_en     = 1'b0;
        n_wr_entry  = rd_entry;
        n_expired   = 1'b0;
        n_remaining = 16'd0;
        unique case (r_act)
            ACT_START, ACT_STOP, ACT_FORCE: begin
                n_wr_en          = r_busy && r_idx_ok;
                n_wr_entry.stamp = now;
                if (r_act == ACT_START) begin
                    n_wr_entry.limit = r_wait;  // marker waits act as markers
                end else if (r_act == ACT_STOP) begin
                    n_wr_entry.limit = MARK_STOPPED;
                end else begin
                    n_wr_entry.limit = MARK_EXPIRED;
                end
            end
            ACT_CHECK: begin
                if (r_idx_ok) begin
                    if (rd_entry.limit == MARK_EXPIRED) begin
                        n_expired = 1'b1;
                    end else if (rd_entry.limit != MARK_STOPPED &&
                                 elapsed >= rd_entry.limit) begin
                        // latch the expired marker
                        n_expired        = 1'b1;
                        n_wr_en          = r_busy;
                        n_wr_entry.limit = MARK_EXPIRED;
                    end
                end
            end
            ACT_QUERY: begin
                if (r_idx_ok && !is_marker && left <= rd_entry.limit) begin
                    n_remaining = left;
                end
            end
            default: begin
                // tick and unused codes leave the entries alone
            end
        endcase
    end

    // result register: one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_busy;
        end
        if (r_busy) begin
            o_expired   <= n_expired;
            o_remaining <= n_remaining;
            o_fine_now  <= tb.fine_next;
        end
    end

    // execute lasts exactly one cycle
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held past one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item not executed");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("executed item gave no result");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result overlaps an execute cycle");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_wr_en |-> (r_busy && r_idx_ok))
        else $error("entry write outside an execute cycle");

endmodule
`default_nettype wire

// File: tb/tmb_reply_checker.sv
`default_nettype none
module tmb_reply_checker
    import tmb_pkg::*;
#(
    parameter int TIMER_COUNT = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [3:0]  i_timer_index,
    input  wire logic        i_seconds_base,
    input  wire logic [15:0] i_wait_time,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        i_expired,
    input  wire logic [15:0] i_remaining,
    input  wire logic [15:0] i_fine_now,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic        expired;
        logic [15:0] remaining;
        logic [15:0] fine_now;
    } timer_reply_t;

    // own copy of the bank
    logic [15:0] tps;
    logic [15:0] fine_time;
    logic [15:0] sec_time;
    logic [15:0] prescale;
    logic [15:0] limit_tab [TIMER_COUNT];
    logic [15:0] stamp_tab [TIMER_COUNT];

    timer_reply_t timer_replies [$];
    int bad_replies = 0;

    assign o_fail_count = bad_replies;

    initial o_pending = 0;

    task automatic flag_bad_reply(input string msg);
        bad_replies++;
        $display("[%0t] bad reply: %s", $time, msg);
    endtask

    task automatic reset_bank();
        tps       = TPS_RESET;
        fine_time = '0;
        sec_time  = '0;
        prescale  = 16'd1;
        for (int i = 0; i < TIMER_COUNT; i++) begin
            limit_tab[i] = MARK_EXPIRED;
            stamp_tab[i] = '0;
        end
    endtask

    function automatic timer_reply_t step_timer_bank(input logic [2:0] act,
                                                     input logic [3:0] idx,
                                                     input logic secs,
                                                     input logic [15:0] lim_in);
        timer_reply_t r;
        logic [15:0]  now_base;
        logic [15:0]  lim;
        logic [15:0]  elapsed;
        logic [15:0]  left;
        logic         in_bank;
        r        = '0;
        now_base = secs ? sec_time : fine_time;
        in_bank  = idx < TIMER_COUNT;
        case (act)
            ACT_TICK: begin
                fine_time = fine_time + 16'd1;
                prescale  = prescale - 16'd1;
                if (prescale == 16'd0) begin
                    prescale = tps;
                    sec_time = sec_time + 16'd1;
                end
            end
            ACT_START, ACT_STOP, ACT_FORCE: begin
                if (in_bank) begin
                    stamp_tab[idx] = now_base;
                    if (act == ACT_START)
                        limit_tab[idx] = lim_in;
                    else if (act == ACT_STOP)
                        limit_tab[idx] = MARK_STOPPED;
                    else
                        limit_tab[idx] = MARK_EXPIRED;
                end
            end
            ACT_CHECK: begin
                if (in_bank) begin
                    lim     = limit_tab[idx];
                    elapsed = now_base - stamp_tab[idx];
                    if (lim == MARK_EXPIRED) begin
                        r.expired = 1'b1;
                    end else if (lim != MARK_STOPPED && elapsed >= lim) begin
                        limit_tab[idx] = MARK_EXPIRED;
                        r.expired      = 1'b1;
                    end
                end
            end
            ACT_QUERY: begin
                if (in_bank) begin
                    lim  = limit_tab[idx];
                    left = lim - now_base + stamp_tab[idx];
                    if (lim != MARK_STOPPED && lim != MARK_EXPIRED && left <= lim)
                        r.remaining = left;
                end
            end
            default: ;
        endcase
        r.fine_now = fine_time;
        return r;
    endfunction

    // replies first, then register write, then the newly accepted item
    always @(posedge i_clk) begin
        timer_reply_t due;
        if (!i_rst_n) begin
            reset_bank();
            timer_replies.delete();
        end else begin
            if (i_valid) begin
                if (timer_replies.size() == 0) begin
                    flag_bad_reply("reply with no item outstanding");
                end else begin
                    due = timer_replies.pop_front();
                    if (i_expired !== due.expired)
                        flag_bad_reply($sformatf("expired %b, want %b",
                                                 i_expired, due.expired));
                    if (i_remaining !== due.remaining)
                        flag_bad_reply($sformatf("remaining %h, want %h",
                                                 i_remaining, due.remaining));
                    if (i_fine_now !== due.fine_now)
                        flag_bad_reply($sformatf("fine_now %h, want %h",
                                                 i_fine_now, due.fine_now));
                end
            end
            if (i_cfg_we)
                tps = i_cfg_data;
            if (i_start && !i_busy)
                timer_replies.push_back(step_timer_bank(i_action, i_timer_index,
                                                        i_seconds_base, i_wait_time));
        end
        o_pending <= timer_replies.size();
    end

endmodule
`default_nettype wire

// File: tb/tb_timeout_timer_bank_top.sv
`default_nettype none
module tb_timeout_timer_bank_top;
    import tmb_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int TIMER_COUNT = 16;
    // worst run: ~1600 items, each followed by the longest gap, taken
    // several times over
    localparam int LIMIT_CYCLES = 600000;
    // extra idle edges after the drain catch any stray reply
    localparam int END_CYCLES   = 8;

    // action codes the block does not define
    localparam logic [2:0] ACT_UNDEF_6 = 3'd6;
    localparam logic [2:0] ACT_UNDEF_7 = 3'd7;

    // every input starts at a known value
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic [2:0]  i_action       = ACT_TICK;
    logic [3:0]  i_timer_index  = '0;
    logic        i_seconds_base = 1'b0;
    logic [15:0] i_wait_time    = '0;
    logic        i_cfg_we       = 1'b0;
    logic [15:0] i_cfg_data     = '0;

    logic        busy;
    logic        o_valid;
    logic        o_expired;
    logic [15:0] o_remaining;
    logic [15:0] o_fine_now;

    int fail_count;
    int replies_due;
    int cycle_count = 0;

    // stimulus shaping only: which base each timer was last started on,
    // so most checks and queries read the matching base
    logic started_secs [TIMER_COUNT];
    // when low, items go back to back
    logic gaps_on = 1'b1;

    always #(CLK_HALF) i_clk = ~i_clk;

    timeout_timer_bank_top #(
        .TIMER_COUNT    (TIMER_COUNT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_timer_index  (i_timer_index),
        .i_seconds_base (i_seconds_base),
        .i_wait_time    (i_wait_time),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_expired      (o_expired),
        .o_remaining    (o_remaining),
        .o_fine_now     (o_fine_now)
    );

    tmb_reply_checker #(
        .TIMER_COUNT    (TIMER_COUNT)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_timer_index  (i_timer_index),
        .i_seconds_base (i_seconds_base),
        .i_wait_time    (i_wait_time),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (o_valid),
        .i_expired      (o_expired),
        .i_remaining    (o_remaining),
        .i_fine_now     (o_fine_now),
        .o_fail_count   (fail_count),
        .o_pending      (replies_due)
    );

    // Idle length after an item: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Present one item and hold it until the block takes it (start high while
    // busy is low at an edge). start is left high if the next item follows at
    // once, so it is never lowered and raised in the same step.
    task automatic issue(input logic [2:0] act, input logic [3:0] idx,
                         input logic secs, input logic [15:0] lim_in);
        int gap;
        i_action       <= act;
        i_timer_index  <= idx;
        i_seconds_base <= secs;
        i_wait_time    <= lim_in;
        start          <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (act == ACT_START)
            started_secs[idx] = secs;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every reply has come back.
    // The count from the checker is registered, so look from the next edge on.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (replies_due != 0)
            @(posedge i_clk);
    endtask

    // Register write: only called with the block idle.
    task automatic write_tps(input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One random item. Weighted towards starts with short waits followed by
    // ticks, checks and queries, so timers actually run out and get latched;
    // markers, long waits and undefined codes make up the rest.
    task automatic issue_random();
        logic [2:0]  act;
        logic [3:0]  idx;
        logic        secs;
        logic [15:0] w;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 34)
            act = ACT_TICK;
        else if (r < 54)
            act = ACT_START;
        else if (r < 59)
            act = ACT_STOP;
        else if (r < 63)
            act = ACT_FORCE;
        else if (r < 79)
            act = ACT_CHECK;
        else if (r < 95)
            act = ACT_QUERY;
        else if (r < 97)
            act = ACT_UNDEF_6;
        else
            act = ACT_UNDEF_7;

        // crowd a few timers half the time so they interact
        idx  = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3))
                                           : 4'($urandom_range(0, TIMER_COUNT - 1));
        secs = 1'($urandom_range(0, 1));
        if ((act == ACT_CHECK || act == ACT_QUERY) && $urandom_range(0, 4) != 0)
            secs = started_secs[idx];

        r = $urandom_range(0, 99);
        if (r < 50)
            w = secs ? 16'($urandom_range(0, 4)) : 16'($urandom_range(0, 12));
        else if (r < 65)
            w = 16'($urandom_range(0, 200));
        else if (r < 82)
            w = 16'($urandom_range(0, 65535));
        else if (r < 88)
            w = MARK_STOPPED;
        else if (r < 94)
            w = MARK_EXPIRED;
        else
            w = 16'hFFFF - 16'($urandom_range(0, 15));
        issue(act, idx, secs, w);
    endtask

    // A random phase at one prescaler setting, with one full drain part way
    // through and stretches with gaps switched off.
    task automatic run_phase(input logic [15:0] tps_value, input int n_items);
        int hold_at;
        hold_at = $urandom_range(n_items / 4, (3 * n_items) / 4);
        settle();
        write_tps(tps_value);
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (i == hold_at)
                settle();
            issue_random();
        end
    endtask

    // Watchdog: ends a hung run.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout_timer_bank_top test failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < TIMER_COUNT; i++)
            started_secs[i] = 1'b0;

        // synchronous reset, held at the start, never again
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: two ticks per second so the seconds base moves ---
        write_tps(16'd2);
        issue(ACT_QUERY, 4'd0, 1'b0, 16'h0000);      // reset state: expired, nothing left
        issue(ACT_CHECK, 4'd0, 1'b0, 16'h0000);
        issue(ACT_START, 4'd1, 1'b0, 16'd3);
        issue(ACT_QUERY, 4'd1, 1'b0, 16'h0000);
        issue(ACT_TICK,  4'd0, 1'b0, 16'h0000);
        issue(ACT_TICK,  4'd0, 1'b1, 16'hFFFF);
        issue(ACT_CHECK, 4'd1, 1'b0, 16'h0000);      // one tick short
        issue(ACT_TICK,  4'd0, 1'b0, 16'h0000);
        issue(ACT_CHECK, 4'd1, 1'b0, 16'h0000);      // runs out, marker latched
        issue(ACT_QUERY, 4'd1, 1'b0, 16'h0000);
        issue(ACT_START, 4'd2, 1'b1, 16'd1);         // on the seconds base
        issue(ACT_QUERY, 4'd2, 1'b0, 16'h0000);      // read against the fine base
        issue(ACT_TICK,  4'd0, 1'b0, 16'h0000);
        issue(ACT_TICK,  4'd0, 1'b0, 16'h0000);
        issue(ACT_CHECK, 4'd2, 1'b1, 16'h0000);
        issue(ACT_START, 4'd3, 1'b0, MARK_STOPPED);  // wait equal to the stop marker
        issue(ACT_CHECK, 4'd3, 1'b0, 16'h0000);
        issue(ACT_START, 4'd4, 1'b0, MARK_EXPIRED);  // wait equal to the expiry marker
        issue(ACT_CHECK, 4'd4, 1'b0, 16'h0000);
        issue(ACT_START, 4'd15, 1'b1, 16'hFFFF);
        issue(ACT_STOP,  4'd15, 1'b1, 16'h0000);
        issue(ACT_QUERY, 4'd15, 1'b1, 16'h0000);
        issue(ACT_START, 4'd6, 1'b0, 16'h0000);      // zero wait: expired at once
        issue(ACT_FORCE, 4'd6, 1'b0, 16'h0000);
        issue(ACT_UNDEF_6, 4'd15, 1'b1, 16'hFFFF);
        issue(ACT_UNDEF_7, 4'd0, 1'b0, 16'h0000);

        // --- directed: zero prescaler reload, which wraps to the longest seconds period ---
        settle();
        write_tps(16'd0);
        issue(ACT_START, 4'd8, 1'b1, 16'd2);
        issue(ACT_TICK,  4'd0, 1'b0, 16'h0000);
        issue(ACT_TICK,  4'd0, 1'b0, 16'h0000);
        issue(ACT_TICK,  4'd0, 1'b0, 16'h0000);
        issue(ACT_QUERY, 4'd8, 1'b1, 16'h0000);
        issue(ACT_CHECK, 4'd8, 1'b1, 16'h0000);

        // --- random phases across prescaler settings, extremes included ---
        run_phase(16'd1, 260);
        run_phase(16'hFFFF, 240);
        run_phase(16'd5, 260);
        run_phase(16'd0, 200);
        run_phase(16'($urandom_range(2, 40)), 280);
        run_phase(16'd3, 310);

        // drain, then allow for any stray reply
        settle();
        repeat (END_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("timeout_timer_bank_top test passed");
        else
            $display("timeout_timer_bank_top test failed");
        $finish;
    end

endmodule
`default_nettype wire
